// ===== hdl/mass_stability_period_detector_top_macros.svh =====
// Assertion helpers shared by the detector modules.
`ifndef MASS_STABILITY_PERIOD_DETECTOR_TOP_MACROS_SVH
`define MASS_STABILITY_PERIOD_DETECTOR_TOP_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define MSPD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle.
`define MSPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mspd_pkg.sv =====
package mspd_pkg;

  localparam int HISTORY_DEPTH_D = 256;
  localparam int WINDOW_D        = 16;
  localparam int INTERVAL_D      = 16;
  localparam int MIN_LAG_D       = 4;
  localparam int MAX_LAG_D       = 128;

  localparam int MASS_W = 24;
  localparam int ALIVE_W = 21;
  localparam int CONF_W = 16;
  localparam int PER_W = 8;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;
  // Wide accumulator: products of deviations, summed over the history.
  localparam int ACC_W = 128;

  localparam logic [CFG_IDX_W-1:0] REG_STABLE_RATIO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_THR   = 1'd1;

  localparam logic [15:0] STABLE_RATIO_RST = 16'd1000;
  localparam logic [15:0] PERIOD_THR_RST   = 16'd11469;

  // Datapath commands from the controller.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_WRITE,    // store mass, bump pointer
    OP_WIN,      // window min/max scan step
    OP_SUM,      // sum scan step
    OP_VAR,      // variance scan step
    OP_XC,       // cross-correlation step
    OP_LAGEND,   // compare accumulator with best
    OP_DIV,      // one quotient bit
    OP_FINISH    // apply threshold
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        first;   // division: integer bit step; finish: clear result, skip threshold
  } cmd_t;

  typedef struct packed {
    logic scan_done;    // last element of the current scan issued
    logic lag_done;     // last lag evaluated
    logic div_done;
    logic short_hist;   // too few samples for a check
    logic var_zero;
    logic pipe_empty;   // no RAM reads still in flight
  } stat_t;

endpackage

// ===== hdl/mspd_if.sv =====
interface mspd_in_if;
  logic                         valid;
  logic                         ready;
  logic [mspd_pkg::MASS_W-1:0]  mass;
  logic [mspd_pkg::ALIVE_W-1:0] alive_count;
  modport source (output valid, mass, alive_count, input ready);
  modport sink (input valid, mass, alive_count, output ready);
endinterface

// ===== hdl/mspd_out_if.sv =====
interface mspd_out_if;
  logic                               valid;
  logic                               ready;
  logic                               stable;
  logic                               empty_res;
  logic                               checked;
  logic                               periodic;
  logic [mspd_pkg::PER_W-1:0]         period;
  logic signed [mspd_pkg::CONF_W-1:0] confidence;
  modport source (output valid, stable, empty_res, checked, periodic, period, confidence,
                  input ready);
  modport sink (input valid, stable, empty_res, checked, periodic, period, confidence,
                output ready);
endinterface

// ===== hdl/mspd_ram.sv =====
module mspd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/mspd_datapath.sv =====
module mspd_datapath #(
  parameter int HISTORY_DEPTH = mspd_pkg::HISTORY_DEPTH_D,
  parameter int WINDOW        = mspd_pkg::WINDOW_D,
  parameter int MIN_LAG       = mspd_pkg::MIN_LAG_D,
  parameter int MAX_LAG       = mspd_pkg::MAX_LAG_D
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mspd_pkg::cmd_t                   cmd,
  output mspd_pkg::stat_t                  stat,
  input  logic [mspd_pkg::MASS_W-1:0]      in_mass,
  input  logic [mspd_pkg::CFG_W-1:0]       stable_ratio,
  input  logic [mspd_pkg::CFG_W-1:0]       conf_min,
  output logic                             win_stable,
  output logic                             periodic,
  output logic [mspd_pkg::PER_W-1:0]       period,
  output logic signed [mspd_pkg::CONF_W-1:0] confidence
);
  import mspd_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int NW = $clog2(HISTORY_DEPTH + 1);
  localparam int LW = $clog2(MAX_LAG + 1);
  localparam int SUMW = MASS_W + NW;
  localparam int DW = SUMW + 2;       // signed deviation
  localparam int PW = 2 * DW;         // signed product
  localparam int MINN = 3 * MIN_LAG;

  logic [AW-1:0] wp_r;
  logic [NW-1:0] fill_r;
  logic [NW-1:0] idx_r;        // element index of the current scan
  logic [LW-1:0] lag_r, maxlag_r;
  logic          second_r;     // xc: fetching the lagged element
  logic          rd_v_r, rd_v2_r;
  op_t           rd_op_r;
  logic          rd_sec_r, rd_sec2_r, rd_var2_r, prod_var_r;
  logic [AW-1:0] raddr;
  logic [MASS_W-1:0] rdata;
  logic [MASS_W-1:0] mx_r, mn_r;
  logic [SUMW-1:0]   sum_r;
  logic signed [DW-1:0] dev_r, dev_a_r, dev_b;
  logic signed [PW-1:0] prod_r;
  logic          prod_v_r;
  logic signed [ACC_W-1:0] acc_r, var_r, best_r, rem_r;
  logic [LW-1:0] best_lag_r;
  logic [4:0]    qcnt_r;
  logic [15:0]   q_r;
  logic          win_ok;
  logic [NW-1:0] scan_len;
  logic signed [ACC_W-1:0] rem2;

  // History store.
  mspd_ram #(.WIDTH(MASS_W), .DEPTH(HISTORY_DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.op == OP_WRITE),
    .waddr (wp_r),
    .wdata (in_mass),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Read address: oldest + index (+ lag, 2nd operand); window: newest - index.
  always_comb begin
    raddr = wp_r - AW'(fill_r) + AW'(idx_r);
    if (cmd.op == OP_WIN) begin
      raddr = wp_r - AW'(1) - AW'(idx_r);
    end else if (cmd.op == OP_XC && second_r) begin
      raddr = wp_r - AW'(fill_r) + AW'(idx_r) + AW'(lag_r);
    end
  end

  always_comb begin
    scan_len = fill_r;
    if (cmd.op == OP_WIN) begin
      scan_len = NW'(WINDOW);
    end else if (cmd.op == OP_XC) begin
      scan_len = fill_r - NW'(lag_r);
    end
  end

  // Signed deviation n*x - sum of the returning element.
  always_comb begin
    dev_b = DW'(signed'({1'b0, DW'(fill_r) * DW'(rdata)})) - DW'(signed'({1'b0, sum_r}));
  end

  assign stat.scan_done = (cmd.op == OP_XC) ? (second_r && idx_r + 1'b1 >= scan_len)
                                            : (idx_r + 1'b1 >= scan_len);
  assign stat.lag_done   = lag_r >= maxlag_r;
  assign stat.div_done   = qcnt_r == 5'd13;
  assign stat.short_hist = (fill_r < NW'(MINN)) || (maxlag_r < LW'(MIN_LAG));
  assign stat.var_zero   = var_r == '0;
  assign stat.pipe_empty = !rd_v_r && !rd_v2_r && !prod_v_r;

  // Window verdict: 2*range*ratio < max+min, zero mean needs zero range.
  always_comb begin
    logic [MASS_W:0] tot;
    logic [MASS_W+17:0] lhs;
    tot = {1'b0, mx_r} + {1'b0, mn_r};
    lhs = {(MASS_W+1)'(mx_r - mn_r), 1'b0} * 17'(stable_ratio);
    if (tot == '0) win_ok = 1'b1;
    else win_ok = lhs < (MASS_W+18)'(tot);
  end
  assign win_stable = (fill_r >= NW'(WINDOW)) && (WINDOW <= HISTORY_DEPTH) && win_ok;

  assign rem2 = rem_r <<< 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      fill_r   <= '0;
      idx_r    <= '0;
      second_r <= 1'b0;
      rd_v_r   <= 1'b0;
      rd_v2_r  <= 1'b0;
      prod_v_r <= 1'b0;
      periodic <= 1'b0;
      period   <= '0;
      confidence <= '0;
      lag_r    <= '0;
      maxlag_r <= '0;
      qcnt_r   <= '0;
    end else begin
      // Track each issued read through the RAM latency and the product stage.
      rd_v_r    <= (cmd.op == OP_WIN || cmd.op == OP_SUM || cmd.op == OP_VAR ||
                    cmd.op == OP_XC);
      rd_op_r   <= cmd.op;
      rd_sec_r  <= second_r;
      rd_v2_r   <= rd_v_r && (rd_op_r == OP_VAR || rd_op_r == OP_XC);
      prod_v_r  <= rd_v2_r && (rd_var2_r || rd_sec2_r);
      prod_var_r <= rd_var2_r;
      case (cmd.op)
        OP_WRITE: begin
          wp_r <= wp_r + 1'b1;
          if (fill_r < NW'(HISTORY_DEPTH)) fill_r <= fill_r + 1'b1;
          idx_r <= '0;
          second_r <= 1'b0;
          mx_r <= '0;
          mn_r <= '1;
          sum_r <= '0;
          acc_r <= '0;
          var_r <= '0;
          if ((fill_r + 1'b1) / 2 > NW'(MAX_LAG) || fill_r >= NW'(HISTORY_DEPTH))
            maxlag_r <= ((fill_r >= NW'(HISTORY_DEPTH) ? NW'(HISTORY_DEPTH) : fill_r + 1'b1)
                         / 2 > NW'(MAX_LAG)) ? LW'(MAX_LAG)
                        : LW'((fill_r >= NW'(HISTORY_DEPTH) ? NW'(HISTORY_DEPTH)
                               : fill_r + 1'b1) >> 1);
          else
            maxlag_r <= LW'((fill_r + 1'b1) >> 1);
          lag_r <= LW'(MIN_LAG);
          best_r <= '0;
          best_lag_r <= LW'(MIN_LAG);
          qcnt_r <= '0;
        end
        OP_WIN, OP_SUM, OP_VAR: begin
          idx_r <= stat.scan_done ? '0 : idx_r + 1'b1;
        end
        OP_XC: begin
          second_r <= !second_r;
          if (second_r) idx_r <= stat.scan_done ? '0 : idx_r + 1'b1;
        end
        OP_LAGEND: begin
          if (lag_r == LW'(MIN_LAG) || acc_r > best_r) begin
            best_r <= acc_r;
            best_lag_r <= lag_r;
          end
          acc_r <= '0;
          lag_r <= lag_r + 1'b1;
        end
        OP_DIV: begin
          if (cmd.first) begin
            // Integer bit: |best| >= var at most once.
            if ((best_r < 0 ? -best_r : best_r) >= var_r) begin
              rem_r <= (best_r < 0 ? -best_r : best_r) - var_r;
              q_r <= 16'd1;
            end else begin
              rem_r <= best_r < 0 ? -best_r : best_r;
              q_r <= 16'd0;
            end
            qcnt_r <= '0;
          end else begin
            if (rem2 >= var_r) begin
              rem_r <= rem2 - var_r;
              q_r <= {q_r[14:0], 1'b1};
            end else begin
              rem_r <= rem2;
              q_r <= {q_r[14:0], 1'b0};
            end
            qcnt_r <= qcnt_r + 1'b1;
          end
        end
        OP_FINISH: begin
          periodic <= 1'b0;
          period <= '0;
          confidence <= '0;
          if (!cmd.first) begin
            logic signed [CONF_W+1:0] c;
            c = best_r < 0 ? -(CONF_W+2)'(q_r + (rem_r != 0 ? 16'd1 : 16'd0))
                           : (CONF_W+2)'(q_r);
            if (c >= (CONF_W+2)'(signed'(conf_min))) begin
              periodic <= 1'b1;
              period <= PER_W'(best_lag_r);
              confidence <= CONF_W'(c);
            end
          end
        end
        default: begin
        end
      endcase

      // Returning RAM data: window and sum finish here, deviations move on.
      if (rd_v_r) begin
        case (rd_op_r)
          OP_WIN: begin
            if (rdata > mx_r) mx_r <= rdata;
            if (rdata < mn_r) mn_r <= rdata;
          end
          OP_SUM: begin
            sum_r <= sum_r + SUMW'(rdata);
          end
          OP_VAR, OP_XC: begin
            dev_r <= dev_b;
            rd_sec2_r <= rd_sec_r;
            rd_var2_r <= rd_op_r == OP_VAR;
          end
          default: begin
          end
        endcase
      end
      // Hold the first operand of a pair, multiply on the second.
      if (rd_v2_r) begin
        if (!rd_var2_r && !rd_sec2_r) dev_a_r <= dev_r;
        prod_r <= rd_var2_r ? dev_r * dev_r : dev_a_r * dev_r;
      end
      // Accumulate into variance or the current lag.
      if (prod_v_r) begin
        if (prod_var_r) var_r <= var_r + ACC_W'(prod_r);
        else acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  `include "mass_stability_period_detector_top_macros.svh"

  `MSPD_ASSERT_IMPL(a_fill_bound, 1'b1, fill_r <= NW'(HISTORY_DEPTH), "fill count overflow")
  `MSPD_ASSERT_IMPL(a_per_zero, !periodic, period == '0 && confidence == '0,
                    "period held while not periodic")
  `MSPD_ASSERT_NEXT(a_write_wp, cmd.op == OP_WRITE, wp_r == $past(wp_r) + 1'b1,
                    "write pointer did not advance")
endmodule

// ===== hdl/mspd_ctrl.sv =====
module mspd_ctrl #(
  parameter int INTERVAL = mspd_pkg::INTERVAL_D
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic            out_fire,
  input  mspd_pkg::stat_t stat,
  output mspd_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            res_load,
  output logic            out_valid,
  output logic            checked
);
  import mspd_pkg::*;

  localparam int FW = (INTERVAL > 1) ? $clog2(INTERVAL) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_WIN, S_WIN_DRAIN, S_SUM, S_SUM_DRAIN, S_VAR, S_VAR_DRAIN,
    S_XC, S_XC_DRAIN, S_LAGEND, S_DIV0, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t        state_r;
  logic [FW-1:0] frame_r;
  logic          check_r;
  logic          clear_r;

  assign busy = state_r != S_IDLE;
  assign res_load = state_r == S_FIN;
  assign out_valid = state_r == S_OUT;

  // Decode state into datapath command; drain states issue no reads.
  always_comb begin
    cmd.first = 1'b0;
    cmd.op = OP_IDLE;
    case (state_r)
      S_IDLE:   cmd.op = in_fire ? OP_WRITE : OP_IDLE;
      S_WIN:    cmd.op = OP_WIN;
      S_SUM:    cmd.op = OP_SUM;
      S_VAR:    cmd.op = OP_VAR;
      S_XC:     cmd.op = OP_XC;
      S_LAGEND: cmd.op = OP_LAGEND;
      S_DIV0: begin cmd.op = OP_DIV; cmd.first = 1'b1; end
      S_DIV:    cmd.op = OP_DIV;
      S_FIN: begin cmd.op = check_r ? OP_FINISH : OP_IDLE; cmd.first = clear_r; end
      default:  cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      frame_r <= '0;
      check_r <= 1'b0;
      clear_r <= 1'b0;
      checked <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_fire) begin
          state_r <= S_WIN;
          clear_r <= 1'b0;
          if (frame_r == FW'(INTERVAL - 1) || INTERVAL == 1) begin
            frame_r <= '0;
            check_r <= 1'b1;
          end else begin
            frame_r <= frame_r + 1'b1;
            check_r <= 1'b0;
          end
        end
        // Window scan, then wait for the last read to land.
        S_WIN: if (stat.scan_done) state_r <= S_WIN_DRAIN;
        S_WIN_DRAIN: begin
          if (check_r && stat.short_hist) clear_r <= 1'b1;
          state_r <= !check_r ? S_FIN
                     : (stat.short_hist ? S_FIN : S_SUM);
        end
        S_SUM: if (stat.scan_done) state_r <= S_SUM_DRAIN;
        S_SUM_DRAIN: state_r <= S_VAR;
        S_VAR: if (stat.scan_done) state_r <= S_VAR_DRAIN;
        // Drop the lag search when the variance is zero.
        S_VAR_DRAIN: if (stat.pipe_empty) begin
          if (stat.var_zero) begin
            clear_r <= 1'b1;
            state_r <= S_FIN;
          end else begin
            state_r <= S_XC;
          end
        end
        S_XC: if (stat.scan_done) state_r <= S_XC_DRAIN;
        S_XC_DRAIN: if (stat.pipe_empty) state_r <= S_LAGEND;
        S_LAGEND: state_r <= stat.lag_done ? S_DIV0 : S_XC;
        S_DIV0: state_r <= S_DIV;
        S_DIV: if (stat.div_done) state_r <= S_FIN;
        S_FIN: begin
          state_r <= S_OUT;
          checked <= check_r;
        end
        S_OUT: if (out_fire) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "mass_stability_period_detector_top_macros.svh"

  `MSPD_ASSERT_IMPL(a_no_accept_busy, busy, !in_fire, "request accepted while busy")
  `MSPD_ASSERT_NEXT(a_out_after_fin, state_r == S_FIN, state_r == S_OUT,
                    "finish did not present result")
  `MSPD_ASSERT_NEXT(a_out_hold, state_r == S_OUT && !out_fire, state_r == S_OUT,
                    "result dropped before it was taken")
endmodule

// ===== hdl/mass_stability_period_detector_top.sv =====
// Channel  | Dir | Handshake     | Payload
// in_ch    | in  | valid/ready   | mass, alive_count
// out_ch   | out | valid/ready   | stable, empty_res, checked, periodic, period, confidence
// cfg      | in  | write enable  | cfg_index, cfg_data
// A frame without a check runs only the window scan. A check adds scans for mean and
// variance, a scan per lag and the quotient steps, all through the single RAM read port.
// Reset is synchronous; no clearing pass, the fill count guards the history.
// One request is worked at a time; ready stays low until the result is taken.
module mass_stability_period_detector_top #(
  parameter int HISTORY_DEPTH = mspd_pkg::HISTORY_DEPTH_D,
  parameter int WINDOW        = mspd_pkg::WINDOW_D,
  parameter int INTERVAL      = mspd_pkg::INTERVAL_D,
  parameter int MIN_LAG       = mspd_pkg::MIN_LAG_D,
  parameter int MAX_LAG       = mspd_pkg::MAX_LAG_D
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mspd_in_if.sink                           in_ch,
  mspd_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [mspd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mspd_pkg::CFG_W-1:0]        cfg_data
);
  import mspd_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy, res_load, out_valid, checked, win_stable, periodic;
  logic  in_fire, out_fire, empty_r, stable_r;
  logic [PER_W-1:0] period;
  logic signed [CONF_W-1:0] confidence;
  logic [CFG_W-1:0] ratio_r, thr_r;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = !busy;

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= STABLE_RATIO_RST;
      thr_r <= PERIOD_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STABLE_RATIO: ratio_r <= cfg_data;
        REG_PERIOD_THR:   thr_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Capture the per-request flags.
  always_ff @(posedge clk) begin
    if (in_fire) empty_r <= in_ch.alive_count == '0;
    if (res_load) stable_r <= win_stable && !empty_r;
  end

  mspd_ctrl #(.INTERVAL(INTERVAL)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire), .stat(stat),
    .cmd(cmd), .busy(busy), .res_load(res_load), .out_valid(out_valid), .checked(checked)
  );

  mspd_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH), .WINDOW(WINDOW), .MIN_LAG(MIN_LAG),
                  .MAX_LAG(MAX_LAG)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_mass(in_ch.mass),
    .stable_ratio(ratio_r), .conf_min(thr_r), .win_stable(win_stable),
    .periodic(periodic), .period(period), .confidence(confidence)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.stable     = stable_r;
  assign out_ch.empty_res  = empty_r;
  assign out_ch.checked    = checked;
  assign out_ch.periodic   = periodic;
  assign out_ch.period     = period;
  assign out_ch.confidence = confidence;
endmodule

// ===== sim/tb.sv =====
module tb;
  import mspd_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [MASS_W-1:0]  mass;
    logic [ALIVE_W-1:0] alive;
  } frame_t;

  typedef struct {
    logic                     stable;
    logic                     empty_res;
    logic                     checked;
    logic                     periodic;
    logic [PER_W-1:0]         period;
    logic signed [CONF_W-1:0] confidence;
  } frame_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  mspd_in_if  in_bus();
  mspd_out_if out_bus();

  mass_stability_period_detector_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Pending requests and predicted results
  frame_t     frame_q[$];
  frame_res_t res_q[$];

  // Predictor state
  logic [MASS_W-1:0] hist_mem [HISTORY_DEPTH_D];
  int unsigned wr_ptr;
  int unsigned fill_n;
  int unsigned frame_cnt;
  logic        per_flag;
  int unsigned per_lag;
  int          per_conf;
  logic [15:0] ratio_reg;
  logic [15:0] thr_reg;

  int  fail_cnt;
  int  res_cnt;
  int  check_cnt;
  int  periodic_cnt;
  int  stable_cnt;
  bit  idle_on;
  bit  rx_block_go;
  int  rx_block_left;
  int  tx_gap;
  int  rx_gap;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic int unsigned hist_idx(int unsigned n, int unsigned i);
    return (wr_ptr + HISTORY_DEPTH_D - n + i) % HISTORY_DEPTH_D;
  endfunction

  function automatic longint dev_at(int unsigned n, int unsigned i, longint sum);
    return longint'(n) * longint'(hist_mem[hist_idx(n, i)]) - sum;
  endfunction

  // Re-evaluate periodicity over all held samples
  function automatic void eval_period();
    int unsigned n;
    int unsigned max_lag;
    int unsigned best_lag;
    longint sum;
    wide_t var_acc;
    wide_t acc;
    wide_t best;
    wide_t mag;
    wide_t quo;
    wide_t rem;
    int conf;
    int thr;
    n = fill_n;
    per_flag = 1'b0;
    per_lag = 0;
    per_conf = 0;
    if (n < 3 * MIN_LAG_D) return;
    max_lag = n / 2;
    if (max_lag > MAX_LAG_D) max_lag = MAX_LAG_D;
    if (max_lag < MIN_LAG_D) return;
    sum = 0;
    for (int unsigned i = 0; i < n; i++) sum += hist_mem[hist_idx(n, i)];
    var_acc = 0;
    for (int unsigned i = 0; i < n; i++)
      var_acc += wide_t'(dev_at(n, i, sum)) * wide_t'(dev_at(n, i, sum));
    if (var_acc == 0) return;
    best = 0;
    best_lag = 0;
    for (int unsigned lag = MIN_LAG_D; lag <= max_lag; lag++) begin
      acc = 0;
      for (int unsigned i = 0; i + lag < n; i++)
        acc += wide_t'(dev_at(n, i, sum)) * wide_t'(dev_at(n, i + lag, sum));
      if (lag == MIN_LAG_D || acc > best) begin
        best = acc;
        best_lag = lag;
      end
    end
    mag = (best < 0) ? -best : best;
    quo = (mag <<< 14) / var_acc;
    rem = (mag <<< 14) % var_acc;
    conf = (best < 0) ? -(int'(quo) + ((rem != 0) ? 1 : 0)) : int'(quo);
    thr = int'($signed(thr_reg));
    if (conf >= thr) begin
      per_flag = 1'b1;
      per_lag = best_lag;
      per_conf = conf;
    end
  endfunction

  // Work out the result of one accepted frame and queue it
  function automatic void predict_frame(logic [MASS_W-1:0] m, logic [ALIVE_W-1:0] a);
    frame_res_t r;
    logic [MASS_W-1:0] mx;
    logic [MASS_W-1:0] mn;
    logic [MASS_W-1:0] h;
    longint unsigned rng;
    longint unsigned tot;
    hist_mem[wr_ptr] = m;
    wr_ptr = (wr_ptr + 1) % HISTORY_DEPTH_D;
    if (fill_n < HISTORY_DEPTH_D) fill_n++;
    r.empty_res = (a == 0);
    r.stable = 1'b0;
    r.checked = 1'b0;
    if (fill_n >= WINDOW_D) begin
      mx = '0;
      mn = '1;
      for (int unsigned i = 0; i < WINDOW_D; i++) begin
        h = hist_mem[(wr_ptr + HISTORY_DEPTH_D - 1 - i) % HISTORY_DEPTH_D];
        if (h > mx) mx = h;
        if (h < mn) mn = h;
      end
      rng = mx - mn;
      tot = longint'(mx) + longint'(mn);
      if (tot == 0) r.stable = (rng == 0);
      else r.stable = (2 * rng * ratio_reg) < tot;
      r.stable = r.stable && !r.empty_res;
    end
    frame_cnt++;
    if (frame_cnt >= INTERVAL_D) begin
      frame_cnt = 0;
      eval_period();
      r.checked = 1'b1;
    end
    r.periodic = per_flag;
    r.period = per_lag[PER_W-1:0];
    r.confidence = per_conf[CONF_W-1:0];
    res_q.push_back(r);
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d: %s got %h expected %h", res_cnt, what, got, want);
    fail_cnt++;
  endtask

  // Driver: present queued frames, with random gaps while idling is enabled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) predict_frame(in_bus.mass, in_bus.alive_count);
      if (!in_bus.valid || in_bus.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_bus.valid <= 1'b0;
        end else if (frame_q.size() > 0) begin
          if (idle_on && $urandom_range(0, 5) == 0) begin
            tx_gap = $urandom_range(0, 13);
            in_bus.valid <= 1'b0;
          end else begin
            in_bus.valid       <= 1'b1;
            in_bus.mass        <= frame_q[0].mass;
            in_bus.alive_count <= frame_q[0].alive;
            frame_q.pop_front();
          end
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off
  always @(posedge clk) begin
    if (rx_block_go) rx_block_left <= 400;
    else if (rx_block_left > 0) rx_block_left <= rx_block_left - 1;
  end

  // Monitor: compare each taken result with the oldest prediction
  always @(posedge clk) begin
    frame_res_t e;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (res_q.size() == 0) begin
          $display("unexpected result %0d", res_cnt);
          fail_cnt++;
        end else begin
          e = res_q.pop_front();
          if (out_bus.stable !== e.stable)
            flag_mismatch("stable", 32'(out_bus.stable), 32'(e.stable));
          if (out_bus.empty_res !== e.empty_res)
            flag_mismatch("empty_res", 32'(out_bus.empty_res), 32'(e.empty_res));
          if (out_bus.checked !== e.checked)
            flag_mismatch("checked", 32'(out_bus.checked), 32'(e.checked));
          if (out_bus.periodic !== e.periodic)
            flag_mismatch("periodic", 32'(out_bus.periodic), 32'(e.periodic));
          if (out_bus.period !== e.period)
            flag_mismatch("period", 32'(out_bus.period), 32'(e.period));
          if (out_bus.confidence !== e.confidence)
            flag_mismatch("confidence", 32'(out_bus.confidence), 32'(e.confidence));
          check_cnt += e.checked;
          periodic_cnt += e.checked & e.periodic;
          stable_cnt += e.stable;
        end
        res_cnt++;
      end
      if (rx_block_left > 0) begin
        out_bus.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rx_gap = $urandom_range(0, 13);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic push_frame(logic [MASS_W-1:0] m, logic [ALIVE_W-1:0] a);
    frame_t f;
    f.mass = m;
    f.alive = a;
    frame_q.push_back(f);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_STABLE_RATIO) ratio_reg = data;
    else if (idx == REG_PERIOD_THR) thr_reg = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every request is taken and every result has come, then settle
  task automatic drain();
    @(negedge clk);
    while (frame_q.size() != 0 || in_bus.valid || res_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Mostly periodic sequences with random content, some flat runs and noise
  task automatic push_random(int count);
    int unsigned p;
    int unsigned base;
    int unsigned amp;
    int unsigned pat [32];
    int unsigned sel;
    int unsigned m;
    p = $urandom_range(MIN_LAG_D, 20);
    base = $urandom_range(0, 24'h7FFFFF);
    amp = $urandom_range(0, 24'h3FFFFF);
    for (int i = 0; i < 32; i++) pat[i] = $urandom_range(0, amp);
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) m = base + pat[k % p] + $urandom_range(0, 3);
      else if (sel < 8) m = base + $urandom_range(0, 1);
      else m = $urandom_range(0, 24'hFFFFFF);
      push_frame(m[MASS_W-1:0],
                 ($urandom_range(0, 7) == 0) ? '0 : ALIVE_W'($urandom_range(0, 1048576)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.mass = '0;
    in_bus.alive_count = '0;
    out_bus.ready = 1'b0;
    rx_block_go = 1'b0;
    rx_block_left = 0;
    tx_gap = 0;
    rx_gap = 0;
    idle_on = 1'b1;
    fail_cnt = 0;
    res_cnt = 0;
    check_cnt = 0;
    periodic_cnt = 0;
    stable_cnt = 0;
    wr_ptr = 0;
    fill_n = 0;
    frame_cnt = 0;
    per_flag = 1'b0;
    per_lag = 0;
    per_conf = 0;
    ratio_reg = STABLE_RATIO_RST;
    thr_reg = PERIOD_THR_RST;
    for (int i = 0; i < HISTORY_DEPTH_D; i++) hist_mem[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: all-zero window, empty frames, then field extremes
    for (int i = 0; i < 16; i++) push_frame('0, (i % 2) ? 21'd1 : 21'd0);
    push_frame(24'hFFFFFF, 21'd1048576);
    push_frame(24'hFFFFFF, 21'd1048575);
    push_frame('0, 21'd1048576);
    push_frame(24'hFFFFFF, 21'd0);
    push_frame(24'h800000, 21'h0AAAAA);
    push_frame(24'h7FFFFF, 21'h155555);
    push_frame(24'h000001, 21'd1);
    push_frame(24'hFFFFFE, 21'd2);
    drain();

    // Loose tolerance, any confidence accepted; long receiver stall
    write_reg(REG_STABLE_RATIO, 16'd1);
    write_reg(REG_PERIOD_THR, 16'h8000);
    @(posedge clk);
    rx_block_go <= 1'b1;
    @(posedge clk);
    rx_block_go <= 1'b0;
    push_random(20);
    drain();

    // Tightest tolerance, highest threshold
    write_reg(REG_STABLE_RATIO, 16'hFFFF);
    write_reg(REG_PERIOD_THR, 16'h7FFF);
    push_random(20);
    drain();

    write_reg(REG_STABLE_RATIO, 16'($urandom_range(1, 65535)));
    write_reg(REG_PERIOD_THR, 16'($urandom_range(0, 65535)));
    push_random(20);
    drain();

    // Final part without idling
    idle_on = 1'b0;
    write_reg(REG_STABLE_RATIO, STABLE_RATIO_RST);
    write_reg(REG_PERIOD_THR, 16'd0);
    push_random(20);
    drain();
    repeat (100) @(posedge clk);

    $display("covered %0d frames, %0d periodicity checks (%0d periodic), %0d stable frames",
             res_cnt, check_cnt, periodic_cnt, stable_cnt);
    if (fail_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #(12 * 1000000);
    $display("tb failed");
    $finish;
  end

endmodule

// ===== mass_stability_period_detector_top.f =====
+incdir+hdl
hdl/mspd_pkg.sv
hdl/mspd_if.sv
hdl/mspd_out_if.sv
hdl/mspd_ram.sv
hdl/mspd_datapath.sv
hdl/mspd_ctrl.sv
hdl/mass_stability_period_detector_top.sv
sim/tb.sv
